### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### hw/rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// Tube surface push package
// Constants and types shared by the tube surface push block.
// ----------------------------------------------------------------------------
`default_nettype none
package csp_pkg;
  localparam int unsigned MaxGap = 0;
  localparam logic OpTick = 1'b0;
  localparam logic OpCell = 1'b1;
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] RegLeftX = 3'd0;
  localparam logic [RegIdxW-1:0] RegLeftY = 3'd1;
  localparam logic [RegIdxW-1:0] RegStartLen = 3'd2;
  localparam logic [RegIdxW-1:0] RegFinalLen = 3'd3;
  localparam logic [RegIdxW-1:0] RegStartRad = 3'd4;
  localparam logic [RegIdxW-1:0] RegFinalRad = 3'd5;
  localparam logic [RegIdxW-1:0] RegLenStep = 3'd6;
  localparam logic [RegIdxW-1:0] RegRadStep = 3'd7;
  // Divider widths: numerator 33 x 32 bits, divisor 36 bits.
  localparam int unsigned NumW = 65;
  localparam int unsigned DenW = 36;
  localparam int unsigned QuoW = 65;
  localparam int unsigned CntW = 7;
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/csp_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module csp_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [csp_pkg::NumW-1:0]    num,
  input  wire logic [csp_pkg::DenW-1:0]    den,
  output csp_pkg::div_ctl_t                ctl,
  output logic      [csp_pkg::QuoW-1:0]    quo
);
  import csp_pkg::*;
  logic [NumW-1:0] nsh;
  logic [DenW:0] rem;
  logic [CntW-1:0] cnt;
  logic busy;
  logic done;
  logic [DenW:0] trial;
  logic [DenW:0] sh;
  assign sh = {rem[DenW-1:0], nsh[NumW-1]};
  assign trial = sh - {1'b0, den};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        nsh <= num;
        rem <= '0;
        cnt <= CntW'(NumW);
      end else if (busy) begin
        nsh <= {nsh[NumW-2:0], 1'b0};
        if (!trial[DenW]) begin
          rem <= trial;
          quo <= {quo[QuoW-2:0], 1'b1};
        end else begin
          rem <= sh;
          quo <= {quo[QuoW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign ctl = '{start: start, busy: busy, done: done};
  `ASSERT_CLK(a_div_no_restart, clk, rst, busy |-> !start, "divider restarted while busy")
  `ASSERT_CLK(a_div_done, clk, rst, done |-> !busy, "divider done while busy")
endmodule
`default_nettype wire

### hw/rtl/capsule_surface_push_unit.sv
// ----------------------------------------------------------------------------
// Tube surface push unit
// Grows a tube and pushes query cells out onto its surface.
// ----------------------------------------------------------------------------
// A growth tick steps the run length and radius in S_TICK, then raises its
// result beat in S_OUT. A cell query squares nine offsets in bit serial form
// (three candidate points of three terms; the foot point keeps only its y and
// z terms) and takes a square root one result bit per cycle. When a push is
// due, each axis then runs a serial multiply and a serial division. One item
// is in flight at a time; the result beat is held in an output register and a
// stalled output holds off the next input beat.
`default_nettype none
`include "assert_macros.svh"
module capsule_surface_push_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [csp_pkg::RegIdxW-1:0]   cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // cell_x, cell_y, cell_z, cell_radius, zero pad (bits 0..127)
  input  wire logic [127:0]                  s_tdata,
  // opcode
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // new_x, new_y, new_z, path_distance, moved, on_axis, length_now,
  // radius_now (bits 0..191)
  output logic [191:0]                       m_tdata
);
  import csp_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_SQ, S_SQACC, S_PICK, S_SQRT, S_DECIDE,
    S_DIVGO, S_MUL, S_DIVWAIT, S_AXISDONE, S_OUT
  } state_t;
  state_t state;
  logic [31:0] left_x, left_y, final_length;
  logic [30:0] final_radius, length_step, radius_step;
  logic signed [31:0] run_len;
  logic [30:0] run_rad;
  logic signed [31:0] cx, cy, cz;
  logic [30:0] cr;
  logic signed [31:0] ex;
  logic [67:0] s_end, s_fix, s_foot, best, acc;
  logic [32:0] mcand, mplier;
  logic [66:0] prod;
  logic [5:0] bitc;
  logic [1:0] term, cand;
  logic signed [31:0] px;
  logic [35:0] root, rtry;
  logic [1:0] axis;
  logic [31:0] nx, ny, nz;
  logic moved, on_axis;
  logic div_start;
  div_ctl_t div_ctl;
  logic [QuoW-1:0] quo;
  logic [71:0] rsq;
  logic signed [33:0] dfa, dfb;
  logic [32:0] mag_a;
  logic signed [33:0] base_v, diff_v, sum_v;
  logic signed [66:0] off_s;
  logic [32:0] scale;

  always_comb begin
    ex = ($signed(run_len) < $signed(final_length)) ? run_len : $signed(final_length);
  end

  // Offset of the current term for the current candidate.
  always_comb begin
    dfa = '0;
    unique case (term)
      2'd0: begin
        unique case (cand)
          2'd0: dfa = 34'(ex) - 34'(cx);
          2'd1: dfa = 34'($signed(left_x)) - 34'(cx);
          default: dfa = '0;
        endcase
      end
      2'd1: dfa = 34'($signed(left_y)) - 34'(cy);
      default: dfa = 34'(cz);
    endcase
    mag_a = dfa[33] ? 33'(-dfa) : 33'(dfa);
  end

  assign rtry = root | (36'd1 << bitc);
  assign rsq = 72'(prod) + (72'(root) << (bitc + 6'd1)) + (72'd1 << {bitc, 1'b0});

  // Push arithmetic for the current axis.
  always_comb begin
    unique case (axis)
      2'd0: begin base_v = 34'(px); diff_v = 34'(cx) - 34'(px); end
      2'd1: begin base_v = 34'($signed(left_y)); diff_v = 34'(cy) - 34'($signed(left_y)); end
      default: begin base_v = '0; diff_v = 34'(cz); end
    endcase
    scale = {2'b0, run_rad} + {2'b0, cr};
    off_s = diff_v[33] ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
    sum_v = base_v + 34'(off_s);
  end

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -34'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  csp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod[NumW-1:0]),
    .den({4'b0, root[31:0]} | {root[35:32], 32'b0}), .ctl(div_ctl), .quo(quo)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      div_start <= 1'b0;
      left_x <= '0; left_y <= '0; final_length <= '0;
      final_radius <= '0; length_step <= '0; radius_step <= '0;
      run_len <= '0; run_rad <= '0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          RegLeftX: left_x <= cfg_data;
          RegLeftY: left_y <= cfg_data;
          RegStartLen: run_len <= cfg_data;
          RegFinalLen: final_length <= cfg_data;
          RegStartRad: run_rad <= cfg_data[30:0];
          RegFinalRad: final_radius <= cfg_data[30:0];
          RegLenStep: length_step <= cfg_data[30:0];
          RegRadStep: radius_step <= cfg_data[30:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cx <= s_tdata[31:0]; cy <= s_tdata[63:32]; cz <= s_tdata[95:64];
            cr <= s_tdata[126:96];
            nx <= '0; ny <= '0; nz <= '0; moved <= 1'b0; on_axis <= 1'b0;
            root <= '0;
            state <= (s_tuser == OpTick) ? S_TICK : S_SQ;
            cand <= 2'd0; term <= 2'd0; acc <= '0; bitc <= '0; prod <= '0;
          end
        end
        S_TICK: begin
          if ($signed(run_len) < $signed(final_length))
            run_len <= sat32(34'(run_len) + 34'({1'b0, length_step}));
          if (run_rad < final_radius) begin
            if ({1'b0, run_rad} + {1'b0, radius_step} > 32'h7FFF_FFFF)
              run_rad <= 31'h7FFF_FFFF;
            else
              run_rad <= run_rad + radius_step;
          end
          state <= S_OUT;
        end
        S_SQ: begin
          // Shift-and-add square, one multiplier bit per cycle.
          if (bitc == 6'd0) begin
            mcand <= mag_a; mplier <= mag_a; prod <= '0; bitc <= 6'd33;
          end else begin
            if (mplier[0]) prod <= prod + (67'(mcand) << (6'd33 - bitc));
            mplier <= mplier >> 1;
            bitc <= bitc - 1'b1;
            if (bitc == 6'd1) state <= S_SQACC;
          end
        end
        S_SQACC: begin
          bitc <= '0;
          if (term == 2'd2) begin
            term <= 2'd0;
            unique case (cand)
              2'd0: begin s_end <= acc + 68'(prod); cand <= 2'd1; state <= S_SQ; end
              2'd1: begin s_fix <= acc + 68'(prod); cand <= 2'd2; state <= S_SQ; end
              default: begin s_foot <= acc + 68'(prod); state <= S_PICK; end
            endcase
            acc <= '0;
          end else begin
            acc <= acc + 68'(prod);
            term <= (cand == 2'd2 && term == 2'd0) ? 2'd1 : term + 1'b1;
            state <= S_SQ;
          end
          if (cand == 2'd2 && term == 2'd0) begin
            term <= 2'd1; acc <= '0; state <= S_SQ;
          end
        end
        S_PICK: begin
          if (s_end <= s_fix) begin best <= s_end; px <= ex; end
          else begin best <= s_fix; px <= left_x; end
          if ($signed(cx) > $signed(left_x) && $signed(cx) < ex) begin
            if (!((s_end <= s_fix ? s_end : s_fix) <= s_foot)) begin
              best <= s_foot; px <= cx;
            end
          end
          bitc <= 6'd35; prod <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          // One root bit per cycle; prod holds the square of the root so far.
          if (rsq <= 72'(best)) begin
            prod <= rsq[66:0];
            root <= rtry;
          end
          if (bitc == 6'd0) state <= S_DECIDE;
          else bitc <= bitc - 1'b1;
        end
        S_DECIDE: begin
          nx <= cx; ny <= cy; nz <= cz;
          if ($signed({1'b0, root}) - $signed(38'(cr)) <
              $signed(38'(run_rad)) - $signed(38'(MaxGap))) begin
            if (root == '0) begin
              on_axis <= 1'b1; state <= S_OUT;
            end else begin
              axis <= 2'd0; state <= S_DIVGO; moved <= 1'b1;
            end
          end else state <= S_OUT;
        end
        S_DIVGO: begin
          mcand <= 33'(diff_v[33] ? -diff_v : diff_v);
          mplier <= scale;
          prod <= '0;
          bitc <= 6'd33;
          state <= S_MUL;
        end
        S_MUL: begin
          // Shift-and-add product of offset and scale, one bit per cycle.
          if (mplier[0]) prod <= prod + (67'(mcand) << (6'd33 - bitc));
          mplier <= mplier >> 1;
          bitc <= bitc - 1'b1;
          if (bitc == 6'd1) begin
            div_start <= 1'b1;
            state <= S_DIVWAIT;
          end
        end
        S_DIVWAIT: if (div_ctl.done) state <= S_AXISDONE;
        S_AXISDONE: begin
          unique case (axis)
            2'd0: nx <= sat32(sum_v);
            2'd1: ny <= sat32(sum_v);
            default: nz <= sat32(sum_v);
          endcase
          if (axis == 2'd2) state <= S_OUT;
          else begin axis <= axis + 1'b1; state <= S_DIVGO; end
        end
        S_OUT: begin
          if (!m_tvalid) m_tvalid <= 1'b1;
          else if (m_tready) begin m_tvalid <= 1'b0; state <= S_IDLE; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {run_rad, run_len, on_axis, moved,
                    (root > 36'h7FFF_FFFF) ? 31'h7FFF_FFFF : root[30:0],
                    nz, ny, nx};

  `ASSERT_CLK(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !s_tready, "accept while busy")
  `ASSERT_CLK(a_out_only_in_out, clk, rst, m_tvalid |-> (state == S_OUT), "beat outside output")
  `ASSERT_CLK(a_flags_excl, clk, rst, m_tvalid |-> !(moved && on_axis), "moved and on_axis")
endmodule
`default_nettype wire
